>>> rtl/erbr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and the quarter-wave sine table builder.
package erbr_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int RATE_BITS        = 16;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int QUARTER_BITS = ANGLE_BITS - 2;
    localparam int ROM_ADDR_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TRIG_FRAC    = 15;
    localparam int TRIG_MAG_W   = 15;
    localparam int TRIG_W       = TRIG_MAG_W + 1;
    localparam int CFG_INDEX_W  = 3;
    localparam int FLAG_W       = 3;

    // Datapath widths: trig x rate products, the rounded trig cross terms,
    // their products with the yaw rate, and the summing accumulator.
    localparam int PROD_W       = TRIG_W + RATE_BITS;
    localparam int CROSS_W      = TRIG_W + 1;
    localparam int CROSS_PROD_W = CROSS_W + RATE_BITS;
    localparam int ACC_W        = CROSS_PROD_W + 2;
    localparam int SUM_W        = ACC_W - TRIG_FRAC;

    localparam logic signed [RATE_BITS-1:0] RATE_LIMIT_RESET = RATE_BITS'(3072);

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned PI2Q30  = 64'd1686629713;
    localparam longint unsigned SINE_SAT = 64'd32767;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROLL_RATE_MIN  = 3'd0,
        REG_ROLL_RATE_MAX  = 3'd1,
        REG_PITCH_RATE_MIN = 3'd2,
        REG_PITCH_RATE_MAX = 3'd3,
        REG_YAW_RATE_MIN   = 3'd4,
        REG_YAW_RATE_MAX   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [RATE_BITS-1:0]  euler_roll_rate;
        logic signed [RATE_BITS-1:0]  euler_pitch_rate;
        logic signed [RATE_BITS-1:0]  euler_yaw_rate;
    } request_t;

    typedef struct packed {
        logic signed [RATE_BITS-1:0] body_roll_rate;
        logic signed [RATE_BITS-1:0] body_pitch_rate;
        logic signed [RATE_BITS-1:0] body_yaw_rate;
        logic [FLAG_W-1:0]           clamp_flags;
    } result_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0]    sin_roll;
        logic signed [TRIG_W-1:0]    cos_roll;
        logic signed [TRIG_W-1:0]    sin_pitch;
        logic signed [TRIG_W-1:0]    cos_pitch;
        logic signed [RATE_BITS-1:0] euler_roll_rate;
        logic signed [RATE_BITS-1:0] euler_pitch_rate;
        logic signed [RATE_BITS-1:0] euler_yaw_rate;
    } trig_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] p;
        logic signed [SUM_W-1:0] q;
        logic signed [SUM_W-1:0] r;
    } sum_item_t;

    typedef logic [TRIG_MAG_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    // Degree-13 Taylor sine in Horner form, each stage truncated in Q2.30.
    // Evaluated only while the design elaborates.
    function automatic logic [TRIG_MAG_W-1:0] quarter_sine(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        begin
            x  = (PI2Q30 * 64'(i)) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 156;
            t  = Q30_ONE - ((x2 * t) >> 30) / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > SINE_SAT)
            begin
                s = SINE_SAT;
            end
            return TRIG_MAG_W'(s);
        end
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        begin
            for (int unsigned i = 0; i <= SINE_TABLE_DEPTH; i++)
            begin
                rom[i] = quarter_sine(i);
            end
            return rom;
        end
    endfunction

endpackage

>>> rtl/euler_rate_to_body_rate_clamp.sv
`timescale 1ns / 1ps
// A request accepted at a clock edge passes through the registered angle fold, the table read,
// the first products, the rounded cross terms, the yaw-rate products, the sums and the clamp
// stage; its result is then on the result ports, with done high for a single cycle.
// Throughput: one request per clock; busy never rises.
// Reset: rst_n clears the pipeline valid bits and loads every limit to +/-3072.
// The receiver takes each result in the cycle it is shown.
module euler_rate_to_body_rate_clamp import erbr_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  request_t               request,
    output logic                   done,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RATE_BITS-1:0]   cfg_data
);

    logic       req_accept;
    logic       trig_valid;
    trig_item_t trig_item;
    logic       sum_valid;
    sum_item_t  sum_item;

    assign busy       = 1'b0;
    assign cfg_ready  = 1'b1;
    assign req_accept = start & ~busy;

    erbr_trig u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_accept),
        .in_item   (request),
        .out_valid (trig_valid),
        .out_item  (trig_item)
    );

    erbr_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .in_item   (trig_item),
        .out_valid (sum_valid),
        .out_item  (sum_item)
    );

    erbr_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (sum_valid),
        .in_item   (sum_item),
        .done      (done),
        .result    (result)
    );

endmodule

>>> rtl/erbr_trig.sv
`timescale 1ns / 1ps
// Angle to sine and cosine lookup: quadrant fold, then registered table read.
module erbr_trig import erbr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  request_t   in_item,
    output logic       out_valid,
    output trig_item_t out_item
);

    localparam int SCALE_W = QUARTER_BITS + ROM_ADDR_W;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << QUARTER_BITS;

    // One table copy per angle, each read at two addresses a cycle.
    localparam sine_rom_t SINE_ROM_ROLL  = build_sine_rom();
    localparam sine_rom_t SINE_ROM_PITCH = build_sine_rom();

    typedef struct packed {
        logic [ROM_ADDR_W-1:0] addr;
        logic                  neg;
    } rom_req_t;

    function automatic rom_req_t phase_to_rom(input logic [ANGLE_BITS-1:0] phase);
        rom_req_t              rq;
        logic [SCALE_W-1:0]    scaled;
        logic [ROM_ADDR_W-1:0] idx;
        begin
            scaled  = SCALE_W'(phase[QUARTER_BITS-1:0]) * SCALE_W'(SINE_TABLE_DEPTH);
            idx     = ROM_ADDR_W'(scaled >> QUARTER_BITS);
            // Odd quadrants run the table backwards; the upper half is negated.
            rq.addr = phase[QUARTER_BITS] ? (ROM_ADDR_W'(SINE_TABLE_DEPTH) - idx) : idx;
            rq.neg  = phase[ANGLE_BITS-1];
            return rq;
        end
    endfunction

    function automatic logic signed [TRIG_W-1:0] apply_sign(
        input logic [TRIG_MAG_W-1:0] mag,
        input logic                  neg
    );
        logic signed [TRIG_W-1:0] ext;
        begin
            ext = signed'(TRIG_W'(mag));
            return neg ? -ext : ext;
        end
    endfunction

    rom_req_t sin_roll_next,  sin_roll_reg;
    rom_req_t cos_roll_next,  cos_roll_reg;
    rom_req_t sin_pitch_next, sin_pitch_reg;
    rom_req_t cos_pitch_next, cos_pitch_reg;
    logic signed [RATE_BITS-1:0] rr_reg, pr_reg, yr_reg;
    logic       valid1_reg;
    logic       valid2_reg;
    trig_item_t trig_next, trig_reg;

    always_comb
    begin
        sin_roll_next  = phase_to_rom(in_item.roll_angle);
        cos_roll_next  = phase_to_rom(ANGLE_BITS'(in_item.roll_angle + QUARTER_TURN));
        sin_pitch_next = phase_to_rom(in_item.pitch_angle);
        cos_pitch_next = phase_to_rom(ANGLE_BITS'(in_item.pitch_angle + QUARTER_TURN));
    end

    always_comb
    begin
        trig_next.sin_roll  = apply_sign(SINE_ROM_ROLL[sin_roll_reg.addr], sin_roll_reg.neg);
        trig_next.cos_roll  = apply_sign(SINE_ROM_ROLL[cos_roll_reg.addr], cos_roll_reg.neg);
        trig_next.sin_pitch = apply_sign(SINE_ROM_PITCH[sin_pitch_reg.addr],
                                         sin_pitch_reg.neg);
        trig_next.cos_pitch = apply_sign(SINE_ROM_PITCH[cos_pitch_reg.addr],
                                         cos_pitch_reg.neg);
        trig_next.euler_roll_rate  = rr_reg;
        trig_next.euler_pitch_rate = pr_reg;
        trig_next.euler_yaw_rate   = yr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sin_roll_reg  <= sin_roll_next;
        cos_roll_reg  <= cos_roll_next;
        sin_pitch_reg <= sin_pitch_next;
        cos_pitch_reg <= cos_pitch_next;
        rr_reg        <= in_item.euler_roll_rate;
        pr_reg        <= in_item.euler_pitch_rate;
        yr_reg        <= in_item.euler_yaw_rate;
        trig_reg      <= trig_next;
    end

    assign out_valid = valid2_reg;
    assign out_item  = trig_reg;

endmodule

>>> rtl/erbr_mul.sv
`timescale 1ns / 1ps
// Product and sum pipeline that forms the unclamped body rates.
module erbr_mul import erbr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  trig_item_t in_item,
    output logic       out_valid,
    output sum_item_t  out_item
);

    localparam int RND_W = PROD_W + 1;
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (TRIG_FRAC - 1);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (TRIG_FRAC - 1);

    logic [3:0] valid_reg;

    // Stage A: all first-level products.
    logic signed [PROD_W-1:0]    cpsr_prod_reg, cpcr_prod_reg;
    logic signed [PROD_W-1:0]    sp_yr_a_reg, cr_pr_a_reg, sr_pr_a_reg;
    logic signed [RATE_BITS-1:0] rr_a_reg, yr_a_reg;

    // Stage B: rounded cross terms.
    logic signed [RND_W-1:0]     cpsr_acc, cpcr_acc;
    logic signed [CROSS_W-1:0]   cpsr_next, cpcr_next, cpsr_reg, cpcr_reg;
    logic signed [PROD_W-1:0]    sp_yr_b_reg, cr_pr_b_reg, sr_pr_b_reg;
    logic signed [RATE_BITS-1:0] rr_b_reg, yr_b_reg;

    // Stage C: cross terms times the yaw rate.
    logic signed [CROSS_PROD_W-1:0] q_yaw_reg, r_yaw_reg;
    logic signed [PROD_W-1:0]       sp_yr_c_reg, cr_pr_c_reg, sr_pr_c_reg;
    logic signed [RATE_BITS-1:0]    rr_c_reg;

    // Stage D: sums rounded once to the rate format.
    logic signed [ACC_W-1:0] p_acc, q_acc, r_acc;
    sum_item_t               sum_next, sum_reg;

    always_comb
    begin
        cpsr_acc  = RND_W'(cpsr_prod_reg) + RND_HALF;
        cpcr_acc  = RND_W'(cpcr_prod_reg) + RND_HALF;
        cpsr_next = CROSS_W'(cpsr_acc >>> TRIG_FRAC);
        cpcr_next = CROSS_W'(cpcr_acc >>> TRIG_FRAC);
    end

    always_comb
    begin
        p_acc = (ACC_W'(rr_c_reg) <<< TRIG_FRAC) - ACC_W'(sp_yr_c_reg) + ACC_HALF;
        q_acc = ACC_W'(cr_pr_c_reg) + ACC_W'(q_yaw_reg) + ACC_HALF;
        r_acc = ACC_W'(r_yaw_reg) - ACC_W'(sr_pr_c_reg) + ACC_HALF;
        sum_next.p = SUM_W'(p_acc >>> TRIG_FRAC);
        sum_next.q = SUM_W'(q_acc >>> TRIG_FRAC);
        sum_next.r = SUM_W'(r_acc >>> TRIG_FRAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        cpsr_prod_reg <= in_item.cos_pitch * in_item.sin_roll;
        cpcr_prod_reg <= in_item.cos_pitch * in_item.cos_roll;
        sp_yr_a_reg   <= in_item.sin_pitch * in_item.euler_yaw_rate;
        cr_pr_a_reg   <= in_item.cos_roll * in_item.euler_pitch_rate;
        sr_pr_a_reg   <= in_item.sin_roll * in_item.euler_pitch_rate;
        rr_a_reg      <= in_item.euler_roll_rate;
        yr_a_reg      <= in_item.euler_yaw_rate;

        cpsr_reg    <= cpsr_next;
        cpcr_reg    <= cpcr_next;
        sp_yr_b_reg <= sp_yr_a_reg;
        cr_pr_b_reg <= cr_pr_a_reg;
        sr_pr_b_reg <= sr_pr_a_reg;
        rr_b_reg    <= rr_a_reg;
        yr_b_reg    <= yr_a_reg;

        q_yaw_reg   <= cpsr_reg * yr_b_reg;
        r_yaw_reg   <= cpcr_reg * yr_b_reg;
        sp_yr_c_reg <= sp_yr_b_reg;
        cr_pr_c_reg <= cr_pr_b_reg;
        sr_pr_c_reg <= sr_pr_b_reg;
        rr_c_reg    <= rr_b_reg;

        sum_reg <= sum_next;
    end

    assign out_valid = valid_reg[3];
    assign out_item  = sum_reg;

endmodule

>>> rtl/erbr_clamp.sv
`timescale 1ns / 1ps
// Limit registers and the per-axis clamp with the registered result stage.
module erbr_clamp import erbr_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RATE_BITS-1:0]   cfg_data,
    input  logic                   in_valid,
    input  sum_item_t              in_item,
    output logic                   done,
    output result_t                result
);

    logic signed [RATE_BITS-1:0] roll_min_reg, roll_max_reg;
    logic signed [RATE_BITS-1:0] pitch_min_reg, pitch_max_reg;
    logic signed [RATE_BITS-1:0] yaw_min_reg, yaw_max_reg;

    logic signed [SUM_W-1:0] p_lim, q_lim, r_lim;
    result_t                 result_next, result_reg;
    logic                    done_reg;

    // The lower bound goes first, so a minimum above the maximum yields the maximum.
    function automatic logic signed [SUM_W-1:0] clamp_val(
        input logic signed [SUM_W-1:0]     v,
        input logic signed [RATE_BITS-1:0] lo,
        input logic signed [RATE_BITS-1:0] hi
    );
        logic signed [SUM_W-1:0] lo_ext;
        logic signed [SUM_W-1:0] hi_ext;
        logic signed [SUM_W-1:0] lim;
        begin
            lo_ext = SUM_W'(lo);
            hi_ext = SUM_W'(hi);
            lim    = (v < lo_ext) ? lo_ext : v;
            lim    = (lim > hi_ext) ? hi_ext : lim;
            return lim;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_min_reg  <= -RATE_LIMIT_RESET;
            roll_max_reg  <= RATE_LIMIT_RESET;
            pitch_min_reg <= -RATE_LIMIT_RESET;
            pitch_max_reg <= RATE_LIMIT_RESET;
            yaw_min_reg   <= -RATE_LIMIT_RESET;
            yaw_max_reg   <= RATE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROLL_RATE_MIN:  roll_min_reg  <= cfg_data;
                REG_ROLL_RATE_MAX:  roll_max_reg  <= cfg_data;
                REG_PITCH_RATE_MIN: pitch_min_reg <= cfg_data;
                REG_PITCH_RATE_MAX: pitch_max_reg <= cfg_data;
                REG_YAW_RATE_MIN:   yaw_min_reg   <= cfg_data;
                REG_YAW_RATE_MAX:   yaw_max_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        p_lim = clamp_val(in_item.p, roll_min_reg, roll_max_reg);
        q_lim = clamp_val(in_item.q, pitch_min_reg, pitch_max_reg);
        r_lim = clamp_val(in_item.r, yaw_min_reg, yaw_max_reg);
        result_next.body_roll_rate  = RATE_BITS'(p_lim);
        result_next.body_pitch_rate = RATE_BITS'(q_lim);
        result_next.body_yaw_rate   = RATE_BITS'(r_lim);
        result_next.clamp_flags     = {r_lim != in_item.r, q_lim != in_item.q,
                                       p_lim != in_item.p};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> dv/euler_rate_to_body_rate_clamp_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Euler-rate to body-rate transform with per-axis clamping.
module euler_rate_to_body_rate_clamp_tb;
    import erbr_pkg::*;

    localparam int     CLK_HALF        = 5;
    localparam int     RESET_CYCLES    = 10;
    localparam int     PIPE_LATENCY    = 8;
    localparam int     MAX_GAP         = 17;
    localparam int     ITEMS_PER_PHASE = 66;
    localparam int     RANDOM_PHASES   = 5;
    localparam int     DRAIN_LIMIT     = 500;
    localparam longint CYCLE_LIMIT     = 200000;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [FLAG_W-1:0] CLAMP_NONE = 3'b000;
    localparam logic [FLAG_W-1:0] CLAMP_P    = 3'b001;
    localparam logic [FLAG_W-1:0] CLAMP_Q    = 3'b010;

    localparam logic [RATE_BITS-1:0] RATE_MOST_POS = {1'b0, {(RATE_BITS-1){1'b1}}};
    localparam logic [RATE_BITS-1:0] RATE_MOST_NEG = {1'b1, {(RATE_BITS-1){1'b0}}};

    typedef struct {
        request_t req;
        bit       typed;
        result_t  want;
    } stim_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    request_t               request   = '0;
    logic                   done;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [RATE_BITS-1:0]   cfg_data  = '0;

    logic [TRIG_MAG_W-1:0]       sine_quarter [0:SINE_TABLE_DEPTH];
    logic signed [RATE_BITS-1:0] rate_lo [3];
    logic signed [RATE_BITS-1:0] rate_hi [3];
    result_t                     body_rate_q [$];
    stim_row_t                   stim_table [$];

    int     err_count      = 0;
    int     checked_count  = 0;
    int     clamped_count  = 0;
    int     accepted_count = 0;
    int     setting_count  = 1;
    longint cycle_count    = 0;

    euler_rate_to_body_rate_clamp u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Horner divisors of the Taylor series are (2m)(2m+1), innermost term first.
    function automatic logic [TRIG_MAG_W-1:0] taylor_sine_entry(int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (PI2Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int m = 6; m >= 1; m--)
        begin
            t = Q30_ONE - ((x2 * t) >> 30) / 64'(2 * m * (2 * m + 1));
        end
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > SINE_SAT)
        begin
            s = SINE_SAT;
        end
        return s[TRIG_MAG_W-1:0];
    endfunction

    function automatic longint trig_sine(logic [ANGLE_BITS-1:0] phase);
        logic [1:0]      quad;
        longint unsigned idx;
        longint          mag;
        quad = phase[ANGLE_BITS-1 -: 2];
        idx  = (64'(phase[QUARTER_BITS-1:0]) * SINE_TABLE_DEPTH) >> QUARTER_BITS;
        if (quad[0])
        begin
            mag = longint'(sine_quarter[SINE_TABLE_DEPTH - idx]);
        end
        else
        begin
            mag = longint'(sine_quarter[idx]);
        end
        return quad[1] ? -mag : mag;
    endfunction

    function automatic longint round_q15(longint v);
        return (v + 64'sd16384) >>> TRIG_FRAC;
    endfunction

    function automatic result_t body_rates_of(request_t req);
        logic [ANGLE_BITS-1:0] quarter_turn;
        longint                rr;
        longint                pr;
        longint                yr;
        longint                s_roll;
        longint                c_roll;
        longint                s_pitch;
        longint                c_pitch;
        longint                cp_sr;
        longint                cp_cr;
        longint                raw [3];
        longint                held [3];
        result_t               res;
        quarter_turn = ANGLE_BITS'(1) << QUARTER_BITS;
        rr      = longint'(req.euler_roll_rate);
        pr      = longint'(req.euler_pitch_rate);
        yr      = longint'(req.euler_yaw_rate);
        s_roll  = trig_sine(req.roll_angle);
        c_roll  = trig_sine(req.roll_angle + quarter_turn);
        s_pitch = trig_sine(req.pitch_angle);
        c_pitch = trig_sine(req.pitch_angle + quarter_turn);
        cp_sr   = round_q15(c_pitch * s_roll);
        cp_cr   = round_q15(c_pitch * c_roll);
        raw[0]  = round_q15(rr * 32768 - s_pitch * yr);
        raw[1]  = round_q15(c_roll * pr + cp_sr * yr);
        raw[2]  = round_q15(-s_roll * pr + cp_cr * yr);
        res.clamp_flags = CLAMP_NONE;
        // The lower bound goes first, so an inverted pair always ends at the maximum.
        for (int a = 0; a < 3; a++)
        begin
            held[a] = raw[a];
            if (held[a] < longint'(rate_lo[a]))
            begin
                held[a] = rate_lo[a];
            end
            if (held[a] > longint'(rate_hi[a]))
            begin
                held[a] = rate_hi[a];
            end
            res.clamp_flags[a] = (held[a] != raw[a]);
        end
        res.body_roll_rate  = RATE_BITS'(held[0]);
        res.body_pitch_rate = RATE_BITS'(held[1]);
        res.body_yaw_rate   = RATE_BITS'(held[2]);
        return res;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    function automatic logic [RATE_BITS-1:0] random_rate();
        if ($urandom_range(0, 1) == 1)
        begin
            return RATE_BITS'($urandom);
        end
        return RATE_BITS'($urandom_range(0, 8191) - 4096);
    endfunction

    function automatic void add_row(logic [ANGLE_BITS-1:0] ra, logic [ANGLE_BITS-1:0] pa,
                                    logic [RATE_BITS-1:0] rr, logic [RATE_BITS-1:0] pr,
                                    logic [RATE_BITS-1:0] yr, bit typed,
                                    logic [RATE_BITS-1:0] wp, logic [RATE_BITS-1:0] wq,
                                    logic [RATE_BITS-1:0] wr, logic [FLAG_W-1:0] wf);
        stim_row_t row;
        row.req.roll_angle       = ra;
        row.req.pitch_angle      = pa;
        row.req.euler_roll_rate  = rr;
        row.req.euler_pitch_rate = pr;
        row.req.euler_yaw_rate   = yr;
        row.typed                = typed;
        row.want.body_roll_rate  = wp;
        row.want.body_pitch_rate = wq;
        row.want.body_yaw_rate   = wr;
        row.want.clamp_flags     = wf;
        stim_table.push_back(row);
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (body_rate_q.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", result);
                err_count++;
            end
            else
            begin
                want = body_rate_q.pop_front();
                check_field("body_roll_rate", want.body_roll_rate, result.body_roll_rate);
                check_field("body_pitch_rate", want.body_pitch_rate, result.body_pitch_rate);
                check_field("body_yaw_rate", want.body_yaw_rate, result.body_yaw_rate);
                check_field("clamp_flags", want.clamp_flags, result.clamp_flags);
                checked_count++;
                if (result.clamp_flags != CLAMP_NONE)
                begin
                    clamped_count++;
                end
            end
        end
    end

    task automatic send_request(request_t req, bit typed, result_t typed_want, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        body_rate_q.push_back(typed ? typed_want : body_rates_of(req));
        accepted_count++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [RATE_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ROLL_RATE_MIN:  rate_lo[0] = data;
            REG_ROLL_RATE_MAX:  rate_hi[0] = data;
            REG_PITCH_RATE_MIN: rate_lo[1] = data;
            REG_PITCH_RATE_MAX: rate_hi[1] = data;
            REG_YAW_RATE_MIN:   rate_lo[2] = data;
            REG_YAW_RATE_MAX:   rate_hi[2] = data;
            default: ;
        endcase
    endtask

    // Writes to the two unmapped indexes are mixed in; they must leave the limits alone.
    task automatic program_limits(logic [RATE_BITS-1:0] lo_p, logic [RATE_BITS-1:0] hi_p,
                                  logic [RATE_BITS-1:0] lo_q, logic [RATE_BITS-1:0] hi_q,
                                  logic [RATE_BITS-1:0] lo_r, logic [RATE_BITS-1:0] hi_r);
        write_reg(REG_ROLL_RATE_MIN, lo_p);
        write_reg(REG_ROLL_RATE_MAX, hi_p);
        write_reg(REG_SPARE_6, RATE_BITS'($urandom));
        write_reg(REG_PITCH_RATE_MIN, lo_q);
        write_reg(REG_PITCH_RATE_MAX, hi_q);
        write_reg(REG_YAW_RATE_MIN, lo_r);
        write_reg(REG_YAW_RATE_MAX, hi_r);
        write_reg(REG_SPARE_7, RATE_BITS'($urandom));
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    task automatic program_random_limits();
        logic [RATE_BITS-1:0] bound [6];
        for (int a = 0; a < 3; a++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                bound[2*a]   = RATE_BITS'($urandom);
                bound[2*a+1] = RATE_BITS'($urandom);
            end
            else
            begin
                bound[2*a]   = RATE_BITS'(-$urandom_range(0, 6000));
                bound[2*a+1] = RATE_BITS'($urandom_range(0, 6000));
            end
        end
        program_limits(bound[0], bound[1], bound[2], bound[3], bound[4], bound[5]);
    endtask

    task automatic run_random(int count);
        bit       steady;
        int       gap;
        request_t req;
        steady = $urandom_range(0, 1);
        for (int n = 0; n < count; n++)
        begin
            // Alternate between back-to-back stretches and gapped stretches.
            if ($urandom_range(0, 15) == 0)
            begin
                steady = ~steady;
            end
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            req.roll_angle       = ANGLE_BITS'($urandom);
            req.pitch_angle      = ANGLE_BITS'($urandom);
            req.euler_roll_rate  = random_rate();
            req.euler_pitch_rate = random_rate();
            req.euler_yaw_rate   = random_rate();
            send_request(req, 1'b0, '0, gap);
        end
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (body_rate_q.size() != 0 && waited < DRAIN_LIMIT);
        if (body_rate_q.size() != 0)
        begin
            $error("%0d results never arrived", body_rate_q.size());
            err_count++;
            body_rate_q.delete();
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            sine_quarter[i] = taylor_sine_entry(i);
        end
        for (int a = 0; a < 3; a++)
        begin
            rate_lo[a] = -RATE_LIMIT_RESET;
            rate_hi[a] = RATE_LIMIT_RESET;
        end

        // At zero angles sine is 0 and cosine is full scale, so these rows are read off directly.
        add_row(16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0, 1'b1,
                16'd0, 16'd0, 16'd0, CLAMP_NONE);
        add_row(16'h0000, 16'h0000, 16'd3072, 16'd0, 16'd0, 1'b1,
                16'd3072, 16'd0, 16'd0, CLAMP_NONE);
        add_row(16'h0000, 16'h0000, RATE_MOST_POS, 16'd0, 16'd0, 1'b1,
                16'd3072, 16'd0, 16'd0, CLAMP_P);
        add_row(16'h0000, 16'h0000, RATE_MOST_NEG, 16'd0, 16'd0, 1'b1,
                -16'sd3072, 16'd0, 16'd0, CLAMP_P);
        add_row(16'h0000, 16'h0000, -16'sd3073, 16'd0, 16'd0, 1'b1,
                -16'sd3072, 16'd0, 16'd0, CLAMP_P);
        add_row(16'h0000, 16'h0000, 16'd0, RATE_MOST_NEG, 16'd0, 1'b1,
                16'd0, -16'sd3072, 16'd0, CLAMP_Q);
        // Quadrant boundaries, angle extremes and alternating bit patterns.
        add_row(16'h8000, 16'h0000, 16'd1000, 16'd2000, -16'sd1500, 1'b0, '0, '0, '0, '0);
        add_row(16'h4000, 16'h4000, 16'd500, 16'd500, 16'd500, 1'b0, '0, '0, '0, '0);
        add_row(16'hC000, 16'hC000, -16'sd500, 16'd700, 16'd900, 1'b0, '0, '0, '0, '0);
        add_row(16'h7FFF, 16'h8000, RATE_MOST_POS, RATE_MOST_POS, RATE_MOST_POS, 1'b0,
                '0, '0, '0, '0);
        add_row(16'h3FFF, 16'hBFFF, RATE_MOST_NEG, RATE_MOST_NEG, RATE_MOST_NEG, 1'b0,
                '0, '0, '0, '0);
        add_row(16'h0001, 16'hFFFF, 16'd1, -16'sd1, 16'd1, 1'b0, '0, '0, '0, '0);
        add_row(16'h2000, 16'h2000, RATE_MOST_POS, RATE_MOST_NEG, RATE_MOST_POS, 1'b0,
                '0, '0, '0, '0);
        add_row(16'hE000, 16'h6000, 16'd0, 16'd3000, -16'sd3000, 1'b0, '0, '0, '0, '0);
        add_row(16'hFFFF, 16'h7FFF, RATE_MOST_NEG, 16'd0, RATE_MOST_NEG, 1'b0, '0, '0, '0, '0);
        add_row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0, '0, '0, '0);
        add_row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0, '0, '0, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[k])
        begin
            send_request(stim_table[k].req, stim_table[k].typed, stim_table[k].want,
                         $urandom_range(0, MAX_GAP));
        end
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        // Limits at the rails of the rate format: only sums beyond the 16-bit range clamp.
        program_limits(RATE_MOST_NEG, RATE_MOST_POS, RATE_MOST_NEG, RATE_MOST_POS,
                       RATE_MOST_NEG, RATE_MOST_POS);
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        // Minimum above maximum on every axis.
        program_limits(16'd1000, -16'sd1000, 16'd0, -16'sd1, RATE_MOST_POS, RATE_MOST_NEG);
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        // Minimum equal to maximum, at zero and at both rails.
        program_limits(16'd0, 16'd0, RATE_MOST_NEG, RATE_MOST_NEG, RATE_MOST_POS, RATE_MOST_POS);
        run_random(ITEMS_PER_PHASE);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            program_random_limits();
            run_random(ITEMS_PER_PHASE);
            wait_idle();
        end

        repeat (PIPE_LATENCY) @(posedge clk);

        $display("Sent %0d requests (%0d from the directed table) under %0d limit settings.",
                 accepted_count, stim_table.size(), setting_count);
        $display("Checked %0d results; %0d had at least one axis clamped.",
                 checked_count, clamped_count);
        if (err_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
